>>> rtl/core/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Request and result layouts, operation codes and the decoded command that
// travels from the front end to the execution back end.
// ----------------------------------------------------------------------------
package ght_pkg;

  // Fixed field widths of the request and result layouts
  localparam int PAYLOAD_W = 32;
  localparam int INDEX_W   = 8;
  localparam int GEN_W     = 56;
  localparam int COUNT_W   = 9;

  // Command queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Raw function codes of a request
  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_RELEASE,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [PAYLOAD_W-1:0] payload_in;
    logic [INDEX_W-1:0]   handle_index;
    logic [GEN_W-1:0]     handle_generation;
  } request_t;

  typedef struct packed {
    logic                 ok;
    logic [INDEX_W-1:0]   out_index;
    logic [GEN_W-1:0]     out_generation;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COUNT_W-1:0]   retired_total;
  } result_t;

  // Classified request as held in the command queue
  typedef struct packed {
    op_t                  op;
    logic [PAYLOAD_W-1:0] payload;
    logic [INDEX_W-1:0]   index;
    logic                 in_range;
    logic [GEN_W-1:0]     generation;
  } cmd_t;

endpackage

>>> rtl/core/ght_front.sv
// ----------------------------------------------------------------------------
// ght_front: request intake and command queue
// Decodes each accepted request, masks its index and payload, flags an
// out-of-range index and holds the command in a two-entry queue.
// ----------------------------------------------------------------------------
module ght_front #(
  parameter int CAPACITY     = 64,
  parameter int IDX_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ght_pkg::request_t request,
  output logic              busy,
  output logic              cmd_valid,
  output ght_pkg::cmd_t     cmd,
  input  logic              pop
);

  localparam int PAY_KEEP = (PAYLOAD_BITS < ght_pkg::PAYLOAD_W) ?
                            PAYLOAD_BITS : ght_pkg::PAYLOAD_W;
  localparam logic [ght_pkg::PAYLOAD_W-1:0] PAY_MASK =
    {ght_pkg::PAYLOAD_W{1'b1}} >> (ght_pkg::PAYLOAD_W - PAY_KEEP);
  localparam logic [ght_pkg::INDEX_W-1:0] IDX_MASK =
    {ght_pkg::INDEX_W{1'b1}} >> (ght_pkg::INDEX_W - IDX_BITS);
  localparam logic [ght_pkg::INDEX_W:0] CAP_LIMIT = (ght_pkg::INDEX_W + 1)'(CAPACITY);

  ght_pkg::cmd_t                 decoded;
  ght_pkg::cmd_t                 queue [ght_pkg::QUEUE_DEPTH];
  logic [ght_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ght_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ght_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic [ght_pkg::INDEX_W-1:0]   index_m;

  // Classify the incoming request
  always_comb begin
    index_m             = request.handle_index & IDX_MASK;
    decoded.payload     = request.payload_in & PAY_MASK;
    decoded.index       = index_m;
    decoded.in_range    = ({1'b0, index_m} < CAP_LIMIT);
    decoded.generation  = request.handle_generation;
    unique case (request.func)
      ght_pkg::FUNC_INSERT:  decoded.op = ght_pkg::OP_INSERT;
      ght_pkg::FUNC_LOOKUP:  decoded.op = ght_pkg::OP_LOOKUP;
      ght_pkg::FUNC_RELEASE: decoded.op = ght_pkg::OP_RELEASE;
      ght_pkg::FUNC_UNUSED:  decoded.op = ght_pkg::OP_NOP;
    endcase
  end

  assign busy      = (count == ght_pkg::QCNT_W'(ght_pkg::QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/ght_back.sv
// ----------------------------------------------------------------------------
// ght_back: slot table execution
// Takes one command from the queue, reads the addressed slot, checks the
// handle, writes the slot back and registers the result.
// ----------------------------------------------------------------------------
module ght_back #(
  parameter int CAPACITY        = 64,
  parameter int GENERATION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  ght_pkg::cmd_t    cmd,
  output logic             pop,
  output logic             done,
  output ght_pkg::result_t result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int GW = GENERATION_BITS;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_RESOLVE = 2'b10
  } state_t;

  state_t                         state;
  state_t                         state_next;

  // Slot storage
  logic [GW-1:0]                  gen_mem [CAPACITY];
  logic [ght_pkg::PAYLOAD_W-1:0]  pay_mem [CAPACITY];
  logic [CAPACITY-1:0]            gen_written;
  logic [CAPACITY-1:0]            busy_flags;
  logic [CAPACITY-1:0]            dead_flags;
  logic [CW-1:0]                  dead_count;
  logic [CW-1:0]                  dead_count_next;

  // Free slot search
  logic [CAPACITY-1:0]            free;
  logic [CAPACITY-1:0]            lowest;
  logic [AW-1:0]                  free_idx;
  logic                           free_any;
  logic [AW-1:0]                  addr_sel;

  // Command in flight and its slot read
  ght_pkg::cmd_t                  cur;
  logic [AW-1:0]                  addr;
  logic                           cur_free_any;
  logic [GW-1:0]                  rd_gen;
  logic [ght_pkg::PAYLOAD_W-1:0]  rd_pay;
  logic                           rd_written;
  logic                           rd_busy;
  logic                           rd_dead;

  logic [GW-1:0]                  slot_gen;
  logic                           handle_ok;
  logic                           at_limit;
  logic                           do_insert;
  logic                           do_release;
  ght_pkg::result_t               result_next;

  // Isolate the lowest free slot and encode its index
  assign free     = ~busy_flags & ~dead_flags;
  assign lowest   = free & (~free + CAPACITY'(1));
  assign free_any = |free;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) begin
        free_idx = free_idx | AW'(i);
      end
    end
  end

  assign pop      = (state == S_IDLE) && cmd_valid;
  assign addr_sel = (cmd.op == ght_pkg::OP_INSERT) ? free_idx : cmd.index[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (cmd_valid) state_next = S_RESOLVE;
      S_RESOLVE: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Resolve the command against the slot that was read
  assign slot_gen   = rd_written ? rd_gen : GW'(1);
  assign at_limit   = &slot_gen;
  assign handle_ok  = cur.in_range && rd_busy && !rd_dead &&
                      (ght_pkg::GEN_W'(slot_gen) == cur.generation);
  assign do_insert  = (state == S_RESOLVE) && (cur.op == ght_pkg::OP_INSERT) && cur_free_any;
  assign do_release = (state == S_RESOLVE) && (cur.op == ght_pkg::OP_RELEASE) && handle_ok;
  assign dead_count_next = (do_release && at_limit) ? dead_count + 1'b1 : dead_count;

  always_comb begin
    result_next                = '0;
    result_next.retired_total  = ght_pkg::COUNT_W'(dead_count_next);
    unique case (cur.op)
      ght_pkg::OP_INSERT: begin
        if (cur_free_any) begin
          result_next.ok             = 1'b1;
          result_next.out_index      = ght_pkg::INDEX_W'(addr);
          result_next.out_generation = ght_pkg::GEN_W'(slot_gen);
        end
      end
      ght_pkg::OP_LOOKUP: begin
        if (handle_ok) begin
          result_next.ok          = 1'b1;
          result_next.payload_out = rd_pay;
        end
      end
      ght_pkg::OP_RELEASE: begin
        result_next.ok = handle_ok;
      end
      ght_pkg::OP_NOP: begin
        result_next.ok = 1'b0;
      end
    endcase
  end

  // Slot memories: read on pop, write back while resolving
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_gen <= gen_mem[addr_sel];
      rd_pay <= pay_mem[addr_sel];
    end
    if (do_insert) begin
      pay_mem[addr] <= cur.payload;
    end
    if (do_release && !at_limit) begin
      gen_mem[addr] <= slot_gen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur          <= cmd;
      addr         <= addr_sel;
      cur_free_any <= free_any;
      rd_written   <= gen_written[addr_sel];
      rd_busy      <= busy_flags[addr_sel];
      rd_dead      <= dead_flags[addr_sel];
    end
    if (state == S_RESOLVE) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      gen_written <= '0;
      busy_flags  <= '0;
      dead_flags  <= '0;
      dead_count  <= '0;
    end else begin
      state      <= state_next;
      done       <= (state == S_RESOLVE);
      dead_count <= dead_count_next;
      if (do_insert) begin
        busy_flags[addr] <= 1'b1;
      end
      if (do_release) begin
        busy_flags[addr] <= 1'b0;
        if (at_limit) begin
          dead_flags[addr] <= 1'b1;
        end else begin
          gen_written[addr] <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table: slot table with generation-checked handles
// Insert, lookup and release of payloads through index/generation handles.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the request is taken at
//   a rising edge where start is high and busy is low. busy rises only when
//   the two-entry command queue is full.
//   Result channel: done is high for exactly one cycle with result valid in
//   that cycle. The receiver cannot hold results off; it must take each one.
//   Path: a taken request passes through its queue entry, the back end's
//   command and slot-read registers and then the result register.
//   Back end: it takes a new request only once it is through with the last
//   one, reading one slot from the slot memories and writing it back in the
//   next cycle. The front end keeps taking requests while the back end works.
//   Insert takes the lowest slot that is neither occupied nor retired; a
//   release at the top generation retires the slot for good.
//   Reset: synchronous rst empties the queue, marks every slot free with
//   generation 1 and clears the retired count. No clearing pass is needed,
//   the block takes requests in the cycle after reset.
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int CAPACITY        = 64,
  parameter int GENERATION_BITS = 16,
  parameter int IDX_BITS        = 8,
  parameter int PAYLOAD_BITS    = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ght_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output ght_pkg::result_t  result
);

  // Command queue link between front and back end
  logic          cmd_valid;
  ght_pkg::cmd_t cmd;
  logic          pop;

  // Front end: classify requests and hold them in the queue
  ght_front #(
    .CAPACITY     (CAPACITY),
    .IDX_BITS     (IDX_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  // Back end: read the slot, check the handle, write back, report
  ght_back #(
    .CAPACITY        (CAPACITY),
    .GENERATION_BITS (GENERATION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule

>>> rtl/core/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker: port-level checks of the generational handle table
// Watches the result strobe and result fields over time.
// ----------------------------------------------------------------------------
module ght_checker #(
  parameter int CAPACITY = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             done,
  input ght_pkg::result_t result
);

  localparam logic [ght_pkg::COUNT_W-1:0] CAP_COUNT = ght_pkg::COUNT_W'(CAPACITY);

  // The back end returns to its idle state between requests, so results never abut
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe high in two consecutive cycles");

  // Reset drops the result strobe
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe high right after reset");

  // A refused request reports nothing but the retired count
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |->
      (result.out_index == '0 && result.out_generation == '0 &&
       result.payload_out == '0))
    else $error("failed request carries nonzero handle or payload");

  // The retired count cannot pass the number of slots
  a_retired_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.retired_total <= CAP_COUNT))
    else $error("retired count above capacity");

endmodule

bind generational_handle_table ght_checker #(
  .CAPACITY (CAPACITY)
) u_ght_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);
